// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// expression must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// ===== rtl/core/pse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pkg
// Types and fixed constants shared by the stable bit key extractor modules.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int CNT_W     = 10;
  localparam int COUNT_CAP = 512;
  localparam int WORD_W    = 32;
  localparam int STAT_W    = 8;
  localparam int BYTE_W    = 8;
  localparam int BCNT_W    = 4;
  localparam int Q_DEPTH   = 2;

  // one device byte after compaction of its stable bits
  typedef struct packed {
    logic [BYTE_W-1:0] bits;   // stable bits, first stable bit in bit 0
    logic [BCNT_W-1:0] cnt;    // number of stable bits
    logic [BCNT_W-1:0] ones;   // stable ones
  } dev_t;

  typedef struct packed {
    dev_t a;
    dev_t b;
    logic last;
  } item_t;

  // head of the queue between front and back
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_t;

  typedef struct packed {
    logic [CNT_W-1:0] stable;
    logic [CNT_W-1:0] zeros;
    logic [CNT_W-1:0] ones;
  } stats_t;

  typedef enum logic [1:0] {
    REP_IDLE,
    REP_DIST,
    REP_SEND
  } rep_phase_t;

endpackage

// ===== rtl/core/pse_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pse_front
// Takes input requests, compacts the stable bits of each device byte and
// holds the classified bytes in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module pse_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [pse_pkg::BYTE_W-1:0] in_data_a,
  input  logic [pse_pkg::BYTE_W-1:0] in_mask_a,
  input  logic [pse_pkg::BYTE_W-1:0] in_data_b,
  input  logic [pse_pkg::BYTE_W-1:0] in_mask_b,
  input  logic                       in_last_byte,
  input  logic                       q_pop,
  output pse_pkg::q_t                q
);

  localparam int PTR_W = $clog2(pse_pkg::Q_DEPTH);
  localparam int QC_W  = $clog2(pse_pkg::Q_DEPTH + 1);

  pse_pkg::item_t     slot_r [pse_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]    count_r, count_nxt;
  logic               push_ok;
  logic               pop_ok;
  pse_pkg::item_t     item_in;

  // scan lsb first, packing stable bits down to bit 0
  function automatic pse_pkg::dev_t classify(input logic [pse_pkg::BYTE_W-1:0] data,
                                             input logic [pse_pkg::BYTE_W-1:0] mask);
    pse_pkg::dev_t d;
    d = '0;
    for (int j = 0; j < pse_pkg::BYTE_W; j++) begin
      if (mask[j]) begin
        d.bits[d.cnt[2:0]] = data[j];
        d.cnt  = d.cnt + pse_pkg::BCNT_W'(1);
        d.ones = d.ones + pse_pkg::BCNT_W'(data[j]);
      end
    end
    return d;
  endfunction

  always_comb begin
    item_in.a    = classify(in_data_a, in_mask_a);
    item_in.b    = classify(in_data_b, in_mask_b);
    item_in.last = in_last_byte;
  end

  assign in_full = (count_r == QC_W'(pse_pkg::Q_DEPTH));
  assign push_ok = in_push && !in_full;
  assign pop_ok  = q_pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = push_ok ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QC_W'(push_ok) - QC_W'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot_r[wr_ptr_r] <= item_in;
    end
  end

  assign q.valid = (count_r != '0);
  assign q.item  = slot_r[rd_ptr_r];

  `ASSERT_NEVER(a_queue_bound, count_r > QC_W'(pse_pkg::Q_DEPTH), "queue count overflow")

endmodule

// ===== rtl/core/pse_lane.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pse_lane
// Per-device accumulator: drops compacted stable bits into the key and
// keeps the saturating bit counters and the key ones count.
// ----------------------------------------------------------------------------
module pse_lane #(
  parameter int KEY_BITS = 128
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  take,
  input  logic                                  last,
  input  pse_pkg::dev_t                         dev,
  output logic [((KEY_BITS+31)/32)*32-1:0]      key_nxt,
  output pse_pkg::stats_t                       st_nxt,
  output logic [$clog2(KEY_BITS+1)-1:0]         ko_nxt
);

  localparam int TOT  = ((KEY_BITS + 31) / 32) * 32;
  localparam int KI_W = $clog2(TOT);
  localparam int KO_W = $clog2(KEY_BITS + 1);
  localparam int PX_W = pse_pkg::CNT_W + 1;

  logic [TOT-1:0]                key_r;
  pse_pkg::stats_t               st_r;
  logic [KO_W-1:0]               ko_r;
  logic [PX_W-1:0]               pos_ext;
  logic [pse_pkg::BCNT_W-1:0]    ko_add;

  function automatic logic [pse_pkg::CNT_W-1:0] sat_add(
    input logic [pse_pkg::CNT_W-1:0]  v,
    input logic [pse_pkg::BCNT_W-1:0] d
  );
    logic [pse_pkg::CNT_W:0] sum;
    sum = {1'b0, v} + (pse_pkg::CNT_W + 1)'(d);
    if (sum > (pse_pkg::CNT_W + 1)'(pse_pkg::COUNT_CAP)) begin
      return pse_pkg::CNT_W'(pse_pkg::COUNT_CAP);
    end
    return sum[pse_pkg::CNT_W-1:0];
  endfunction

  // key bit n sits at key_r[TOT-1-n], so word 0 fills from its msb down
  always_comb begin
    key_nxt = key_r;
    ko_add  = '0;
    pos_ext = '0;
    for (int i = 0; i < pse_pkg::BYTE_W; i++) begin
      pos_ext = {1'b0, st_r.stable} + PX_W'(i);
      if ((pse_pkg::BCNT_W'(i) < dev.cnt) && (pos_ext < PX_W'(KEY_BITS))) begin
        key_nxt[KI_W'(TOT - 1) - pos_ext[KI_W-1:0]] = dev.bits[i];
        ko_add = ko_add + pse_pkg::BCNT_W'(dev.bits[i]);
      end
    end
  end

  always_comb begin
    st_nxt.stable = sat_add(st_r.stable, dev.cnt);
    st_nxt.ones   = sat_add(st_r.ones, dev.ones);
    st_nxt.zeros  = sat_add(st_r.zeros, dev.cnt - dev.ones);
    ko_nxt        = ko_r + KO_W'(ko_add);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      st_r  <= '0;
      ko_r  <= '0;
    end else if (take) begin
      if (last) begin
        key_r <= '0;
        st_r  <= '0;
        ko_r  <= '0;
      end else begin
        key_r <= key_nxt;
        st_r  <= st_nxt;
        ko_r  <= ko_nxt;
      end
    end
  end

  `ASSERT_CLK(a_key_ones_le_stable,
    (PX_W'(ko_r) <= {1'b0, st_r.stable}), "key ones exceed stable count")

endmodule

// ===== rtl/core/pse_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pse_back
// Accumulates both devices from the queue, snapshots the session on the last
// byte, sweeps the key words for the distance and hands out the report.
// ----------------------------------------------------------------------------
module pse_back #(
  parameter int KEY_BITS = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pse_pkg::q_t                       q,
  output logic                              q_pop,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [pse_pkg::WORD_W-1:0]        out_key_word_a,
  output logic [pse_pkg::WORD_W-1:0]        out_key_word_b,
  output logic [pse_pkg::CNT_W-1:0]         out_stable_a,
  output logic [pse_pkg::CNT_W-1:0]         out_zeros_a,
  output logic [pse_pkg::CNT_W-1:0]         out_ones_a,
  output logic [pse_pkg::CNT_W-1:0]         out_stable_b,
  output logic [pse_pkg::CNT_W-1:0]         out_zeros_b,
  output logic [pse_pkg::CNT_W-1:0]         out_ones_b,
  output logic [pse_pkg::STAT_W-1:0]        out_key_ones_a,
  output logic [pse_pkg::STAT_W-1:0]        out_key_ones_b,
  output logic [pse_pkg::STAT_W-1:0]        out_key_distance,
  output logic                              out_last_word
);

  localparam int KW   = (KEY_BITS + 31) / 32;
  localparam int TOT  = KW * pse_pkg::WORD_W;
  localparam int KO_W = $clog2(KEY_BITS + 1);
  localparam int WI_W = (KW > 1) ? $clog2(KW) : 1;
  localparam int PC_W = $clog2(pse_pkg::WORD_W + 1);

  logic [TOT-1:0]          key_nxt_a, key_nxt_b;
  pse_pkg::stats_t         st_nxt_a, st_nxt_b;
  logic [KO_W-1:0]         ko_nxt_a, ko_nxt_b;

  pse_pkg::rep_phase_t     phase_r, phase_nxt;
  logic [WI_W-1:0]         idx_r, idx_nxt;
  logic                    idx_last;
  logic                    capture;

  logic [TOT-1:0]          rep_key_a_r, rep_key_b_r;
  pse_pkg::stats_t         rep_st_a_r, rep_st_b_r;
  logic [KO_W-1:0]         rep_ko_a_r, rep_ko_b_r;
  logic [KO_W-1:0]         dist_r;
  logic [pse_pkg::WORD_W-1:0] word_a, word_b;

  function automatic logic [PC_W-1:0] popcount32(input logic [pse_pkg::WORD_W-1:0] v);
    logic [PC_W-1:0] n;
    n = '0;
    for (int i = 0; i < pse_pkg::WORD_W; i++) begin
      n = n + PC_W'(v[i]);
    end
    return n;
  endfunction

  pse_lane #(.KEY_BITS(KEY_BITS)) u_lane_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (q_pop),
    .last    (q.item.last),
    .dev     (q.item.a),
    .key_nxt (key_nxt_a),
    .st_nxt  (st_nxt_a),
    .ko_nxt  (ko_nxt_a)
  );

  pse_lane #(.KEY_BITS(KEY_BITS)) u_lane_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (q_pop),
    .last    (q.item.last),
    .dev     (q.item.b),
    .key_nxt (key_nxt_b),
    .st_nxt  (st_nxt_b),
    .ko_nxt  (ko_nxt_b)
  );

  // a closing byte waits until the previous report has drained
  assign q_pop    = q.valid && (!q.item.last || (phase_r == pse_pkg::REP_IDLE));
  assign capture  = q_pop && q.item.last;
  assign idx_last = (idx_r == WI_W'(KW - 1));

  assign word_a = rep_key_a_r[pse_pkg::WORD_W*(KW-1-int'(idx_r)) +: pse_pkg::WORD_W];
  assign word_b = rep_key_b_r[pse_pkg::WORD_W*(KW-1-int'(idx_r)) +: pse_pkg::WORD_W];

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    out_empty = 1'b1;
    case (phase_r)
      pse_pkg::REP_IDLE: begin
        if (capture) begin
          phase_nxt = pse_pkg::REP_DIST;
          idx_nxt   = '0;
        end
      end
      pse_pkg::REP_DIST: begin
        if (idx_last) begin
          phase_nxt = pse_pkg::REP_SEND;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + WI_W'(1);
        end
      end
      pse_pkg::REP_SEND: begin
        out_empty = 1'b0;
        if (out_pop) begin
          if (idx_last) begin
            phase_nxt = pse_pkg::REP_IDLE;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + WI_W'(1);
          end
        end
      end
      default: begin
        phase_nxt = pse_pkg::REP_IDLE;
        idx_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pse_pkg::REP_IDLE;
      idx_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      rep_key_a_r <= key_nxt_a;
      rep_key_b_r <= key_nxt_b;
      rep_st_a_r  <= st_nxt_a;
      rep_st_b_r  <= st_nxt_b;
      rep_ko_a_r  <= ko_nxt_a;
      rep_ko_b_r  <= ko_nxt_b;
      dist_r      <= '0;
    end else if (phase_r == pse_pkg::REP_DIST) begin
      dist_r <= dist_r + KO_W'(popcount32(word_a ^ word_b));
    end
  end

  assign out_key_word_a   = word_a;
  assign out_key_word_b   = word_b;
  assign out_stable_a     = rep_st_a_r.stable;
  assign out_zeros_a      = rep_st_a_r.zeros;
  assign out_ones_a       = rep_st_a_r.ones;
  assign out_stable_b     = rep_st_b_r.stable;
  assign out_zeros_b      = rep_st_b_r.zeros;
  assign out_ones_b       = rep_st_b_r.ones;
  assign out_key_ones_a   = pse_pkg::STAT_W'(rep_ko_a_r);
  assign out_key_ones_b   = pse_pkg::STAT_W'(rep_ko_b_r);
  assign out_key_distance = pse_pkg::STAT_W'(dist_r);
  assign out_last_word    = idx_last;

  `ASSERT_CLK(a_capture_starts_sweep,
    (capture |=> (phase_r == pse_pkg::REP_DIST)), "report capture did not start sweep")
  `ASSERT_CLK(a_sweep_steps,
    (((phase_r == pse_pkg::REP_DIST) && !idx_last) |=> (idx_r == $past(idx_r) + WI_W'(1))),
    "distance sweep skipped a word")
  `ASSERT_CLK(a_dist_bound,
    ((phase_r != pse_pkg::REP_IDLE) |-> (dist_r <= KO_W'(KEY_BITS))), "distance beyond key size")

endmodule

// ===== rtl/core/puf_stable_bit_key_extractor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// puf_stable_bit_key_extractor
// Builds a KEY_BITS key per device from masked power-up bytes of two devices
// and reports the keys with bit statistics and their Hamming distance.
// ----------------------------------------------------------------------------
// One byte pair is taken every cycle while in_full is low: the front
// compacts the stable bits of both bytes and queues them, and the back folds
// one queued byte per cycle into the keys and saturating counters. A
// byte flagged last closes the session: its state is captured into a report
// register and the live state clears, so the next session can stream in at
// once. The report first sums the key distance one 32-bit word per cycle
// over all key words, then offers KEY_WORDS results, word 0 first, one per
// pop. A further last byte waits in the queue until the previous report is
// fully popped. The first result of a report is offered when its distance
// sum is complete.
module puf_stable_bit_key_extractor #(
  parameter int KEY_BITS = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [pse_pkg::BYTE_W-1:0]        in_data_a,
  input  logic [pse_pkg::BYTE_W-1:0]        in_mask_a,
  input  logic [pse_pkg::BYTE_W-1:0]        in_data_b,
  input  logic [pse_pkg::BYTE_W-1:0]        in_mask_b,
  input  logic                              in_last_byte,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [pse_pkg::WORD_W-1:0]        out_key_word_a,
  output logic [pse_pkg::WORD_W-1:0]        out_key_word_b,
  output logic [pse_pkg::CNT_W-1:0]         out_stable_a,
  output logic [pse_pkg::CNT_W-1:0]         out_zeros_a,
  output logic [pse_pkg::CNT_W-1:0]         out_ones_a,
  output logic [pse_pkg::CNT_W-1:0]         out_stable_b,
  output logic [pse_pkg::CNT_W-1:0]         out_zeros_b,
  output logic [pse_pkg::CNT_W-1:0]         out_ones_b,
  output logic [pse_pkg::STAT_W-1:0]        out_key_ones_a,
  output logic [pse_pkg::STAT_W-1:0]        out_key_ones_b,
  output logic [pse_pkg::STAT_W-1:0]        out_key_distance,
  output logic                              out_last_word
);

  pse_pkg::q_t q;
  logic        q_pop;

  pse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data_a    (in_data_a),
    .in_mask_a    (in_mask_a),
    .in_data_b    (in_data_b),
    .in_mask_b    (in_mask_b),
    .in_last_byte (in_last_byte),
    .q_pop        (q_pop),
    .q            (q)
  );

  pse_back #(.KEY_BITS(KEY_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q                (q),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_key_word_a   (out_key_word_a),
    .out_key_word_b   (out_key_word_b),
    .out_stable_a     (out_stable_a),
    .out_zeros_a      (out_zeros_a),
    .out_ones_a       (out_ones_a),
    .out_stable_b     (out_stable_b),
    .out_zeros_b      (out_zeros_b),
    .out_ones_b       (out_ones_b),
    .out_key_ones_a   (out_key_ones_a),
    .out_key_ones_b   (out_key_ones_b),
    .out_key_distance (out_key_distance),
    .out_last_word    (out_last_word)
  );

endmodule
